// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files that carry checks; only the top-level unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define AF_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define AF_ASSERT(label, clk, rst_n, prop)
`define AF_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== hw/rtl/afrf_pkg.sv =====
// Package with the shared types, constants and arctangent table of the force unit.
`timescale 1ns / 1ps
`default_nettype none
package afrf_pkg;
    localparam int XW = 43;
    localparam int ZW = 27;
    localparam int ATAN_LEN = 24;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam logic signed [ZW-1:0] DEG180 = 27'sd11796480;
    localparam logic [15:0] INV_GAIN = 16'd39797;
    localparam logic signed [12:0] FORCE_LIM = 13'sd2560;
    localparam logic signed [16:0] TURN = 17'sd23040;
    localparam logic signed [16:0] HALF_TURN = 17'sd11520;
    localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;
    localparam logic [15:0] GAIN_RESET = 16'd1280;

    typedef enum logic {
        REG_TEAM_SELECT = 1'b0,
        REG_GAIN        = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic signed [XW-1:0] vx;
        logic signed [XW-1:0] vy;
        logic signed [ZW-1:0] vz;
        logic signed [XW-1:0] rx;
        logic signed [XW-1:0] ry;
        logic signed [ZW-1:0] rz;
        logic signed [15:0]   h;
        logic                 vzero;
    } t_work;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] v;
        unique case (i)
            0: v = 27'sd2949120;
            1: v = 27'sd1740967;
            2: v = 27'sd919879;
            3: v = 27'sd466945;
            4: v = 27'sd234379;
            5: v = 27'sd117304;
            6: v = 27'sd58666;
            7: v = 27'sd29335;
            8: v = 27'sd14668;
            9: v = 27'sd7334;
            10: v = 27'sd3667;
            11: v = 27'sd1833;
            12: v = 27'sd917;
            13: v = 27'sd458;
            14: v = 27'sd229;
            15: v = 27'sd115;
            16: v = 27'sd57;
            17: v = 27'sd29;
            18: v = 27'sd14;
            19: v = 27'sd7;
            20: v = 27'sd4;
            21: v = 27'sd2;
            22: v = 27'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/afrf_front.sv =====
// Front end: accepts a word, selects the pose, forms the deltas and prepares both rotations.
`timescale 1ns / 1ps
`default_nettype none
module afrf_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_team,
    input  wire logic signed [31:0]    i_green_x,
    input  wire logic signed [31:0]    i_green_y,
    input  wire logic signed [15:0]    i_green_heading,
    input  wire logic signed [31:0]    i_orange_x,
    input  wire logic signed [31:0]    i_orange_y,
    input  wire logic signed [15:0]    i_orange_heading,
    input  wire logic signed [31:0]    i_target_x,
    input  wire logic signed [31:0]    i_target_y,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output afrf_pkg::t_work            o_work
);
    import afrf_pkg::*;

    logic                 r_valid;
    t_work                r_work;
    t_work                n_work;
    logic signed [31:0]   px, py;
    logic signed [15:0]   ph;
    logic signed [32:0]   dx33, dy33;
    logic signed [XW-1:0] dx, dy;
    logic signed [16:0]   na, nb;
    logic                 flip;

    always_comb begin
        px = i_team ? i_orange_x : i_green_x;
        py = i_team ? i_orange_y : i_green_y;
        ph = i_team ? i_orange_heading : i_green_heading;
        dx33 = {i_target_x[31], i_target_x} - {px[31], px};
        dy33 = {i_target_y[31], i_target_y} - {py[31], py};
        dx = {{(XW-41){dx33[32]}}, dx33, 8'b0};
        dy = {{(XW-41){dy33[32]}}, dy33, 8'b0};
        na = -{ph[15], ph};
        if (na > HALF_TURN) begin
            na = na - TURN;
        end else if (na <= -HALF_TURN) begin
            na = na + TURN;
        end
        flip = 1'b0;
        nb = na;
        if (na > QUARTER_TURN) begin
            flip = 1'b1;
            nb = na - HALF_TURN;
        end else if (na < -QUARTER_TURN) begin
            flip = 1'b1;
            nb = na + HALF_TURN;
        end
        n_work.h = ph;
        n_work.vzero = (dx == '0) && (dy == '0);
        if (dx < 0) begin
            n_work.vx = -dx;
            n_work.vy = -dy;
            n_work.vz = (dy >= 0) ? DEG180 : -DEG180;
        end else begin
            n_work.vx = dx;
            n_work.vy = dy;
            n_work.vz = '0;
        end
        n_work.rx = flip ? -dx : dx;
        n_work.ry = flip ? -dy : dy;
        n_work.rz = ZW'($signed({nb, 10'b0}));
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/afrf_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none
module afrf_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire afrf_pkg::t_work  i_work,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output afrf_pkg::t_work       o_work
);
    import afrf_pkg::*;

    t_work       r_mem [0:1];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_work  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_mem[r_wp] <= i_work;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/afrf_back.sv =====
// Back end: pipelined vectoring and rotation, gain scaling, saturation and output register.
`timescale 1ns / 1ps
`default_nettype none
module afrf_back #(
    parameter int CORDIC_STEPS = afrf_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire afrf_pkg::t_work    i_work,
    input  wire logic [15:0]        i_gain,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [12:0]      o_force_x,
    output logic signed [12:0]      o_force_y,
    output logic signed [16:0]      o_bearing_out,
    output logic                    o_clipped
);
    import afrf_pkg::*;

    logic                  adv;
    logic                  r_v   [0:CORDIC_STEPS];
    logic signed [XW-1:0]  r_vx  [0:CORDIC_STEPS];
    logic signed [XW-1:0]  r_vy  [0:CORDIC_STEPS];
    logic signed [ZW-1:0]  r_vz  [0:CORDIC_STEPS];
    logic signed [XW-1:0]  r_rx  [0:CORDIC_STEPS];
    logic signed [XW-1:0]  r_ry  [0:CORDIC_STEPS];
    logic signed [ZW-1:0]  r_rz  [0:CORDIC_STEPS];
    logic signed [15:0]    r_h   [0:CORDIC_STEPS];
    logic                  r_zr  [0:CORDIC_STEPS];

    logic                  r_v1, r_v2, r_v3;
    logic signed [59:0]    r_px, r_py;
    logic signed [16:0]    r_bear1, r_bear2, r_bear3;
    logic signed [60:0]    r_qx, r_qy;
    logic signed [12:0]    r_fx, r_fy;
    logic                  r_clip;

    logic signed [ZW-1:0]  zsel;
    logic signed [15:0]    zq;
    logic signed [16:0]    n_bear;
    logic signed [43:0]    mx, my;
    logic signed [61:0]    ex, ey;
    logic signed [37:0]    fx, fy;
    logic signed [12:0]    n_fx, n_fy;
    logic                  n_clip;

    assign adv = !r_v3 || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
        end
        if (adv) begin
            r_vx[0] <= i_work.vx;
            r_vy[0] <= i_work.vy;
            r_vz[0] <= i_work.vz;
            r_rx[0] <= i_work.rx;
            r_ry[0] <= i_work.ry;
            r_rz[0] <= i_work.rz;
            r_h[0]  <= i_work.h;
            r_zr[0] <= i_work.vzero;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (adv) begin
                r_v[i+1] <= r_v[i];
            end
            if (adv) begin
                if (r_vy[i] >= 0) begin
                    r_vx[i+1] <= r_vx[i] + (r_vy[i] >>> i);
                    r_vy[i+1] <= r_vy[i] - (r_vx[i] >>> i);
                    r_vz[i+1] <= r_vz[i] + atan_entry(i);
                end else begin
                    r_vx[i+1] <= r_vx[i] - (r_vy[i] >>> i);
                    r_vy[i+1] <= r_vy[i] + (r_vx[i] >>> i);
                    r_vz[i+1] <= r_vz[i] - atan_entry(i);
                end
                if (r_rz[i] >= 0) begin
                    r_rx[i+1] <= r_rx[i] - (r_ry[i] >>> i);
                    r_ry[i+1] <= r_ry[i] + (r_rx[i] >>> i);
                    r_rz[i+1] <= r_rz[i] - atan_entry(i);
                end else begin
                    r_rx[i+1] <= r_rx[i] + (r_ry[i] >>> i);
                    r_ry[i+1] <= r_ry[i] - (r_rx[i] >>> i);
                    r_rz[i+1] <= r_rz[i] + atan_entry(i);
                end
                r_h[i+1]  <= r_h[i];
                r_zr[i+1] <= r_zr[i];
            end
        end
    end

    always_comb begin
        zsel   = r_zr[CORDIC_STEPS] ? '0 : r_vz[CORDIC_STEPS];
        zq     = 16'((zsel + 27'sd512) >>> 10);
        n_bear = {zq[15], zq} + {r_h[CORDIC_STEPS][15], r_h[CORDIC_STEPS]};
        mx     = 44'(r_px >>> 16);
        my     = 44'(r_py >>> 16);
        ex     = 62'sd8388608 - {r_qx[60], r_qx};
        ey     = 62'sd8388608 - {r_qy[60], r_qy};
        fx     = 38'(ex >>> 24);
        fy     = 38'(ey >>> 24);
        n_clip = 1'b0;
        if (fx > 38'sd2560) begin
            n_fx = FORCE_LIM;
            n_clip = 1'b1;
        end else if (fx < -38'sd2560) begin
            n_fx = -FORCE_LIM;
            n_clip = 1'b1;
        end else begin
            n_fx = 13'(fx);
        end
        if (fy > 38'sd2560) begin
            n_fy = FORCE_LIM;
            n_clip = 1'b1;
        end else if (fy < -38'sd2560) begin
            n_fy = -FORCE_LIM;
            n_clip = 1'b1;
        end else begin
            n_fy = 13'(fy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= r_v[CORDIC_STEPS];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (adv) begin
            r_px    <= r_rx[CORDIC_STEPS] * $signed({1'b0, INV_GAIN});
            r_py    <= r_ry[CORDIC_STEPS] * $signed({1'b0, INV_GAIN});
            r_bear1 <= n_bear;
            r_qx    <= mx * $signed({1'b0, i_gain});
            r_qy    <= my * $signed({1'b0, i_gain});
            r_bear2 <= r_bear1;
            r_fx    <= n_fx;
            r_fy    <= n_fy;
            r_clip  <= n_clip;
            r_bear3 <= r_bear2;
        end
    end

    assign o_valid       = r_v3;
    assign o_force_x     = r_fx;
    assign o_force_y     = r_fy;
    assign o_bearing_out = r_bear3;
    assign o_clipped     = r_clip;
endmodule
`default_nettype wire

// ===== hw/rtl/attractive_force_robot_frame_unit.sv =====
// Path: front register, the two-entry queue, CORDIC_STEPS + 1 CORDIC stages,
// then three scaling stages to the output word; CORDIC and scaling are fully pipelined.
// Throughput: one word per cycle unless i_out_ready stalls; the pipelined path sets it.
// Reset is synchronous and active low; it empties the pipeline and the queue and
// sets team select to green and the gain to 5.0.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module attractive_force_robot_frame_unit #(
    parameter int CORDIC_STEPS = afrf_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [15:0]         i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic signed [31:0]  i_green_x,
    input  wire logic signed [31:0]  i_green_y,
    input  wire logic signed [15:0]  i_green_heading,
    input  wire logic signed [31:0]  i_orange_x,
    input  wire logic signed [31:0]  i_orange_y,
    input  wire logic signed [15:0]  i_orange_heading,
    input  wire logic signed [31:0]  i_target_x,
    input  wire logic signed [31:0]  i_target_y,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [12:0]       o_force_x,
    output logic signed [12:0]       o_force_y,
    output logic signed [16:0]       o_bearing_out,
    output logic                     o_clipped
);
    import afrf_pkg::*;

    logic        r_team;
    logic [15:0] r_gain;
    logic        f_valid, f_ready, q_valid, q_ready;
    t_work       f_work, q_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_team <= 1'b0;
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_TEAM_SELECT: r_team <= i_cfg_data[0];
                REG_GAIN:        r_gain <= i_cfg_data;
                default:         r_gain <= r_gain;
            endcase
        end
    end

    afrf_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_in_valid), .o_ready(o_in_ready), .i_team(r_team),
        .i_green_x, .i_green_y, .i_green_heading,
        .i_orange_x, .i_orange_y, .i_orange_heading,
        .i_target_x, .i_target_y,
        .o_valid(f_valid), .i_ready(f_ready), .o_work(f_work)
    );

    afrf_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_work(f_work),
        .o_valid(q_valid), .i_ready(q_ready), .o_work(q_work)
    );

    afrf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_work(q_work), .i_gain(r_gain),
        .o_valid(o_out_valid), .i_ready(i_out_ready),
        .o_force_x, .o_force_y, .o_bearing_out, .o_clipped
    );

    `AF_ASSERT(a_clip_at_limit, i_clk, i_rst_n, o_out_valid && o_clipped |-> (o_force_x == FORCE_LIM || o_force_x == -FORCE_LIM || o_force_y == FORCE_LIM || o_force_y == -FORCE_LIM))
    `AF_ASSERT(a_force_range, i_clk, i_rst_n, o_out_valid |-> (o_force_x <= FORCE_LIM && o_force_x >= -FORCE_LIM && o_force_y <= FORCE_LIM && o_force_y >= -FORCE_LIM))
    `AF_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)
endmodule
`default_nettype wire
